### design/btmd_pkg.sv
// shared types and character codes for the binary tree minimum depth block
package btmd_pkg;

    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [3:0] depth;
        logic       overflow;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_RUN   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

endpackage

### design/btmd_ram.sv
// generic ram: one write port, two registered read ports, read-first
module btmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

### design/binary_tree_min_depth_top.sv
// top level: tree description parser, child occupancy memories and leaf scan
//
//  channel  direction  signals                              payload
//  request  in         i_in_valid / o_in_ready / i_in_req   t_in  {ch, last}
//  result   out        o_out_valid / i_out_ready / o_out_res t_out {found, depth, overflow}
//
// one character per cycle while o_in_ready is high; a request with last set starts a scan
// of levels 0 to t, t being the deepest level that holds a node (0 if none), one
// node per cycle through the two child memories; after the last read the result is
// loaded once the output register is free, and input is ready again once it is loaded
// after reset a clearing pass zeroes both memories
// a stalled result holds in the output register; the next line is taken meanwhile,
// only the load of its own result waits for the register to drain
module binary_tree_min_depth_top
    import btmd_pkg::*;
#(
    parameter int MAX_LEVELS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_res
);

    localparam int ML    = MAX_LEVELS;
    localparam int AW    = ML - 1;
    localparam int DEPTH = 2 ** AW;
    localparam int LW    = $clog2(MAX_LEVELS + 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [LW-1:0]   r_level, n_level;
    logic [ML-1:0]   r_slot, n_slot;
    logic [ML-1:0]   r_base, n_base;
    logic            r_tok, n_tok;
    logic            r_ovf, n_ovf;
    logic            r_root, n_root;
    logic [LW-1:0]   r_top, n_top;
    logic [ML-1:0]   r_k, n_k;
    logic [LW-1:0]   r_kdep, n_kdep;
    logic [ML-1:0]   r_knext, n_knext;
    logic            r_ev, n_ev;
    logic [ML-1:0]   r_ek, n_ek;
    logic [LW-1:0]   r_edep, n_edep;
    logic            r_found, n_found;
    logic [LW-1:0]   r_fdep, n_fdep;
    logic            r_ovalid, n_ovalid;
    t_out            r_ores, n_ores;

    logic            in_acc;
    logic            is_bar, is_blank, is_star, start_node;
    logic            lvl_ok, slot_ok;
    logic [ML-1:0]   node, node_m1, k_m1, k_last, k_inc;
    logic            advance;
    logic            w_left, w_right, w_data;
    logic [AW-1:0]   w_addr;
    logic            l_kid, r_kid, l_own, r_own;
    logic            own, kids, leaf, out_free;

    assign in_acc = i_in_valid && o_in_ready;

    assign is_bar   = i_in_req.ch == CH_BAR;
    assign is_blank = i_in_req.ch == CH_SPACE ||
                      (i_in_req.ch >= CH_TAB && i_in_req.ch <= CH_CR);
    assign is_star  = i_in_req.ch == CH_STAR;
    assign start_node = !is_bar && !is_blank && !r_tok && !is_star;

    assign lvl_ok  = r_level < LW'(MAX_LEVELS);
    assign slot_ok = lvl_ok && ((r_slot >> r_level) == '0);
    assign advance = !is_bar && !is_blank && !r_tok && slot_ok;

    // node n > 0 lives in entry (n-1)/2 of the left (odd n) or right (even n) memory
    assign node    = r_base + r_slot;
    assign node_m1 = node - ML'(1);
    assign k_m1    = r_k - ML'(1);
    assign k_inc   = r_k + ML'(1);
    assign k_last  = ML'(((ML + 1)'(2) << r_top) - (ML + 1)'(2));

    always_comb begin
        w_addr  = r_clr;
        w_left  = 1'b0;
        w_right = 1'b0;
        w_data  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_left  = 1'b1;
                w_right = 1'b1;
            end
            S_RUN: begin
                w_addr = node_m1[ML-1:1];
                w_data = 1'b1;
                if (in_acc && start_node && slot_ok && r_level != '0) begin
                    w_left  = !node_m1[0];
                    w_right = node_m1[0];
                end
            end
            S_SCAN: begin
                // both nodes of this entry have been checked, drop it for the next line
                w_addr  = k_m1[ML-1:1];
                w_left  = !r_k[0] && r_k != '0;
                w_right = !r_k[0] && r_k != '0;
            end
            default: begin
                w_addr = r_clr;
            end
        endcase
    end

    btmd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_left (
        .i_clk    (i_clk),
        .i_we     (w_left),
        .i_waddr  (w_addr),
        .i_wdata  (w_data),
        .i_raddr0 (r_k[AW-1:0]),
        .i_raddr1 (k_m1[ML-1:1]),
        .o_rdata0 (l_kid),
        .o_rdata1 (l_own)
    );

    btmd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_right (
        .i_clk    (i_clk),
        .i_we     (w_right),
        .i_waddr  (w_addr),
        .i_wdata  (w_data),
        .i_raddr0 (r_k[AW-1:0]),
        .i_raddr1 (k_m1[ML-1:1]),
        .o_rdata0 (r_kid),
        .o_rdata1 (r_own)
    );

    assign own  = (r_ek == '0) ? r_root : (r_ek[0] ? l_own : r_own);
    // nodes on the deepest level have no child entry
    assign kids = !r_ek[ML-1] && (l_kid || r_kid);
    assign leaf = r_ev && own && !kids;

    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_level  = r_level;
        n_slot   = r_slot;
        n_base   = r_base;
        n_tok    = r_tok;
        n_ovf    = r_ovf;
        n_root   = r_root;
        n_top    = r_top;
        n_k      = r_k;
        n_kdep   = r_kdep;
        n_knext  = r_knext;
        n_ev     = 1'b0;
        n_ek     = r_ek;
        n_edep   = r_edep;
        n_found  = r_found;
        n_fdep   = r_fdep;
        n_ovalid = r_ovalid;
        n_ores   = r_ores;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        if (leaf && !r_found) begin
            n_found = 1'b1;
            n_fdep  = r_edep;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (in_acc) begin
                    if (is_bar) begin
                        n_tok  = 1'b0;
                        n_slot = '0;
                        if (lvl_ok) begin
                            n_level = r_level + LW'(1);
                            n_base  = {r_base[ML-2:0], 1'b1};
                        end
                    end else if (is_blank) begin
                        n_tok = 1'b0;
                    end else if (!r_tok && !is_star) begin
                        n_tok = 1'b1;
                        if (slot_ok) begin
                            n_top = r_level;
                            if (r_level == '0) begin
                                n_root = 1'b1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (advance) begin
                        n_slot = r_slot + ML'(1);
                    end
                    if (i_in_req.last) begin
                        n_state = S_SCAN;
                        n_k     = '0;
                        n_kdep  = LW'(1);
                        n_knext = ML'(1);
                        n_found = 1'b0;
                        n_fdep  = '0;
                    end
                end
            end
            S_SCAN: begin
                n_ev   = 1'b1;
                n_ek   = r_k;
                n_edep = r_kdep;
                n_k    = k_inc;
                if (k_inc == r_knext) begin
                    n_kdep  = r_kdep + LW'(1);
                    n_knext = {r_knext[ML-2:0], 1'b1};
                end
                if (r_k == k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_ev && out_free) begin
                    n_ovalid         = 1'b1;
                    n_ores.found     = r_found;
                    n_ores.depth     = 4'(r_fdep);
                    n_ores.overflow  = r_ovf;
                    n_level = '0;
                    n_slot  = '0;
                    n_base  = '0;
                    n_tok   = 1'b0;
                    n_ovf   = 1'b0;
                    n_root  = 1'b0;
                    n_top   = '0;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_level  <= '0;
            r_slot   <= '0;
            r_base   <= '0;
            r_tok    <= 1'b0;
            r_ovf    <= 1'b0;
            r_root   <= 1'b0;
            r_top    <= '0;
            r_ev     <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_level  <= n_level;
            r_slot   <= n_slot;
            r_base   <= n_base;
            r_tok    <= n_tok;
            r_ovf    <= n_ovf;
            r_root   <= n_root;
            r_top    <= n_top;
            r_ev     <= n_ev;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_kdep  <= n_kdep;
        r_knext <= n_knext;
        r_ek    <= n_ek;
        r_edep  <= n_edep;
        r_fdep  <= n_fdep;
        r_ores  <= n_ores;
    end

    assign o_in_ready  = r_state == S_RUN;
    assign o_out_valid = r_ovalid;
    assign o_out_res   = r_ores;

    a_found_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ores.found == (r_ores.depth != 4'd0)))
        else $error("found flag and depth disagree");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_ores.depth <= 4'(MAX_LEVELS))
        else $error("reported depth beyond the level bound");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_k <= k_last)
        else $error("scan index ran past the deepest used level");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && n_state == S_RUN |=>
            r_level == '0 && !r_root && !r_ovf && r_ovalid)
        else $error("line state not cleared when the result was loaded");

    a_eval_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> $past(r_state == S_SCAN))
        else $error("node evaluated without a scan read");

endmodule

### tb/sv/testbench.sv
// testbench for binary_tree_min_depth_top: streamed tree lines, scoreboard of shallowest leaves
module testbench
    import btmd_pkg::*;
();

    localparam int TREE_LEVELS = 8;
    localparam int MAP_SIZE    = 1 << (TREE_LEVELS + 1);
    localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_req = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_res;

    binary_tree_min_depth_top #(
        .MAX_LEVELS(TREE_LEVELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_res  (o_out_res)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: occupancy map and parse position of the current line
    bit          node_map [0:MAP_SIZE-1];
    int unsigned cur_level;
    int unsigned cur_slot;
    int unsigned cur_base;
    bit          in_token;
    bit          refused;

    t_out        leaf_results_q[$];
    logic [7:0]  line_buf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int lines_sent = 0;
    int chars_sent = 0;
    int deepest_leaf = 0;
    int overflow_lines = 0;
    int empty_lines = 0;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void clear_tree();
        foreach (node_map[i]) node_map[i] = 1'b0;
        cur_level = 0;
        cur_slot = 0;
        cur_base = 0;
        in_token = 1'b0;
        refused = 1'b0;
    endfunction

    function void step_slot();
        if (cur_level < TREE_LEVELS && cur_slot < (1 << cur_level)) cur_slot++;
    endfunction

    function void tree_take_char(logic [7:0] c);
        if (c == CH_BAR) begin
            in_token = 1'b0;
            cur_slot = 0;
            if (cur_level < TREE_LEVELS) begin
                cur_level++;
                cur_base = 2 * cur_base + 1;
            end
        end else if (is_blank(c)) begin
            in_token = 1'b0;
        end else if (!in_token) begin
            if (c == CH_STAR) begin
                step_slot();
            end else begin
                in_token = 1'b1;
                if (cur_level < TREE_LEVELS && cur_slot < (1 << cur_level))
                    node_map[cur_base + cur_slot] = 1'b1;
                else
                    refused = 1'b1;
                step_slot();
            end
        end
    endfunction

    // heap-order walk, first node with both children absent
    function automatic int shallowest_leaf_depth();
        int d;
        int next_start;
        d = 1;
        next_start = 1;
        for (int k = 0; k < NODE_COUNT; k++) begin
            if (k == next_start) begin
                d++;
                next_start = 2 * next_start + 1;
            end
            if (node_map[k] && !node_map[2*k+1] && !node_map[2*k+2]) return d;
        end
        return 0;
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    task send_char(logic [7:0] c, logic is_last);
        t_in  req;
        t_out res;
        int   d;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        req.ch = c;
        req.last = is_last;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        chars_sent++;
        tree_take_char(c);
        if (is_last) begin
            d = shallowest_leaf_depth();
            res.found = (d != 0);
            res.depth = d[3:0];
            res.overflow = refused;
            leaf_results_q.push_back(res);
            if (d > deepest_leaf) deepest_leaf = d;
            if (d == 0) empty_lines++;
            if (refused) overflow_lines++;
            clear_tree();
        end
    endtask

    task send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        if (line_buf.size() != 0) lines_sent++;
        line_buf.delete();
    endtask

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function void add_blank();
        int r;
        r = $urandom_range(5);
        line_buf.push_back(r == 5 ? CH_SPACE : CH_TAB + r[7:0]);
    endfunction

    function void add_token();
        logic [7:0] c;
        int len;
        len = $urandom_range(1, 3);
        do c = 8'($urandom_range(255)); while (is_blank(c) || c == CH_BAR || c == CH_STAR);
        line_buf.push_back(c);
        for (int i = 1; i < len; i++) begin
            do c = 8'($urandom_range(255)); while (is_blank(c) || c == CH_BAR);
            line_buf.push_back(c);
        end
    endfunction

    function void add_level_break();
        if ($urandom_range(3) == 0) add_blank();
        line_buf.push_back(CH_BAR);
        if ($urandom_range(3) == 0) add_blank();
    endfunction

    // mostly well-formed level-order lines, some pure noise
    function void build_random_line();
        int mode;
        int r;
        int levels;
        int n;
        logic [7:0] c;
        mode = $urandom_range(9);
        r = $urandom_range(99);
        levels = r < 65 ? $urandom_range(1, 4) : r < 93 ? $urandom_range(5, 7)
                        : $urandom_range(8, 10);
        if (mode >= 8) begin
            n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(99);
                c = r < 25 ? CH_BAR : r < 40 ? CH_STAR : 8'($urandom_range(255));
                line_buf.push_back(c);
            end
        end else begin
            for (int lv = 0; lv < levels; lv++) begin
                if (lv > 0) add_level_break();
                if (mode >= 6) begin
                    // single spine down the left edge, sometimes shifted by an empty slot
                    if ($urandom_range(7) == 0) begin
                        line_buf.push_back(CH_STAR);
                        add_blank();
                    end
                    add_token();
                    add_blank();
                end else begin
                    n = lv <= 3 ? (1 << lv) : $urandom_range(1, 10);
                    if (lv <= 3 && $urandom_range(19) == 0) n += $urandom_range(1, 2);
                    for (int s = 0; s < n; s++) begin
                        if ($urandom_range(3) == 0) line_buf.push_back(CH_STAR);
                        else add_token();
                        if ($urandom_range(5) != 0) add_blank();
                    end
                end
            end
            if (line_buf.size() > 1 && $urandom_range(1) == 1) void'(line_buf.pop_back());
        end
    endfunction

    task test_single_nodes();
        add_text("7");
        send_line();
        add_text(" ");
        send_line();
        // root with right child only, that child is a zero byte
        add_text("a|*\t");
        line_buf.push_back(8'h00);
        send_line();
    endtask

    task test_token_rules();
        // star inside the root token, high byte as the left child
        add_text("a*|");
        line_buf.push_back(8'hFF);
        send_line();
    endtask

    task test_slot_bound();
        add_text("1|2 3 4");
        send_line();
    endtask

    task test_level_bound();
        add_text("x|||||||||y");
        send_line();
        // empty levels past the bound are harmless
        add_text("k|||||||||");
        send_line();
    endtask

    task test_random_lines(int idle_pct, int stall_pct, int n_items);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = chars_sent;
        while (chars_sent - start < n_items) begin
            build_random_line();
            send_line();
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, leaf_results_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (leaf_results_q.size() == 0) begin
                report_mismatch("result with none expected", 1, 0);
            end else begin
                want = leaf_results_q.pop_front();
                if (o_out_res.found !== want.found)
                    report_mismatch("found", int'(o_out_res.found), int'(want.found));
                if (o_out_res.depth !== want.depth)
                    report_mismatch("depth", int'(o_out_res.depth), int'(want.depth));
                if (o_out_res.overflow !== want.overflow)
                    report_mismatch("overflow", int'(o_out_res.overflow),
                                    int'(want.overflow));
                results_checked++;
            end
        end
    end

    initial begin
        clear_tree();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_nodes();
        test_token_rules();
        test_slot_bound();
        test_level_bound();
        test_random_lines(0, 0, 312);
        test_random_lines(67, 0, 312);
        test_random_lines(0, 67, 312);
        test_random_lines(9, 9, 312);
        i_in_valid <= 1'b0;
        while (leaf_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d lines (%0d characters), checked %0d results",
                 lines_sent, chars_sent, results_checked);
        $display("deepest leaf %0d, %0d lines overflowed, %0d empty trees",
                 deepest_leaf, overflow_lines, empty_lines);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
